// ===== rtl/linear_interp_resampler_defines.svh =====
// ----------------------------------------------------------------------------
// linear_interp_resampler_defines
// Assertion macros shared by the resampler RTL. They expect signals named
// clk and rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define LIRS_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lirs: invariant violated");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define LIRS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lirs: implication violated");

`endif

// ===== rtl/lirs_pkg.sv =====
// ----------------------------------------------------------------------------
// lirs_pkg
// Types and constants of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lirs_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_CHANNELS = 8;
    localparam int CHANNEL_W    = 3;
    localparam int CHANS_W      = 4;
    localparam int QUEUE_DEPTH  = 4;

    // Read position and step ratio: FRAC_BITS fraction bits, values below 16.0.
    localparam int POS_W  = FRAC_BITS + 4;
    localparam int STEP_W = POS_W;
    localparam int SUM_W  = POS_W + 1;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = DIFF_W + FRAC_BITS + 1;

    localparam logic [POS_W-1:0] ONE_POS   = POS_W'(1) << FRAC_BITS;
    localparam logic [POS_W-1:0] STEP_MIN  = ONE_POS >> 2;
    localparam logic [POS_W-1:0] STEP_MAX  = ONE_POS << 3;
    localparam logic [POS_W-1:0] POS_BOUND = POS_W'(9) << FRAC_BITS;

    localparam logic [CHANS_W-1:0] CHANS_MAX = CHANS_W'(MAX_CHANNELS);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_RATIO      = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_CHANNELS = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          final_frame;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [CHANNEL_W-1:0]          channel;
        logic                          run_last;
        logic                          stream_done;
    } out_item_t;

    // One classified source frame handed from the front end to the back end.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] prev;
        logic signed [SAMPLE_BITS-1:0] cur;
        logic                          fin;
        logic                          has_prev;
    } cmd_t;

    typedef struct packed {
        logic             idle;
        logic [POS_W-1:0] pos;
    } back_status_t;

endpackage

// ===== rtl/lirs_front.sv =====
// ----------------------------------------------------------------------------
// lirs_front
// Accepts source frames, pairs each with the held previous sample and
// classifies it for the back end.
// ----------------------------------------------------------------------------
module lirs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  lirs_pkg::in_item_t in_data,
    input  logic              q_full,
    output logic              push,
    output lirs_pkg::cmd_t    cmd
);
    import lirs_pkg::*;

    logic signed [SAMPLE_BITS-1:0] held_reg;
    logic signed [SAMPLE_BITS-1:0] held_next;
    logic                          have_prev_reg;
    logic                          have_prev_next;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    assign cmd.prev     = held_reg;
    assign cmd.cur      = in_data.sample_in;
    assign cmd.fin      = in_data.final_frame;
    assign cmd.has_prev = have_prev_reg;

    // A final frame ends the stream; the next word starts from scratch.
    always_comb
    begin
        held_next      = held_reg;
        have_prev_next = have_prev_reg;
        if (push)
        begin
            held_next      = in_data.final_frame ? '0 : in_data.sample_in;
            have_prev_next = !in_data.final_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            have_prev_reg <= have_prev_next;
        end
    end

endmodule

// ===== rtl/lirs_queue.sv =====
// ----------------------------------------------------------------------------
// lirs_queue
// Small first-in first-out queue of classified frames between the front
// end and the back end.
// ----------------------------------------------------------------------------
module lirs_queue #(
    parameter int DEPTH = lirs_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lirs_pkg::cmd_t push_data,
    input  logic           pop,
    output lirs_pkg::cmd_t head,
    output logic           head_valid,
    output logic           full
);
    import lirs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/lirs_back.sv =====
// ----------------------------------------------------------------------------
// lirs_back
// Walks the read position across one source interval, interpolates each
// output position and repeats the sample once per output channel.
// ----------------------------------------------------------------------------
module lirs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lirs_pkg::cmd_t                head,
    input  logic                          head_valid,
    output logic                          pop,
    input  logic [lirs_pkg::STEP_W-1:0]   step,
    input  logic [lirs_pkg::CHANS_W-1:0]  chans,
    output lirs_pkg::out_item_t           out_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output lirs_pkg::back_status_t        status
);
    import lirs_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_A_CALC = 3'd1;
    localparam logic [2:0] S_A_EMIT = 3'd2;
    localparam logic [2:0] S_B_CALC = 3'd3;
    localparam logic [2:0] S_B_EMIT = 3'd4;

    localparam logic [SUM_W-1:0] ONE_SUM = SUM_W'(ONE_POS);
    localparam logic [SUM_W-1:0] TWO_SUM = SUM_W'(ONE_POS) << 1;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [POS_W-1:0]              pos_reg;
    logic [POS_W-1:0]              pos_next;
    logic [CHANNEL_W-1:0]          chan_reg;
    logic [CHANNEL_W-1:0]          chan_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic signed [SAMPLE_BITS-1:0] prev_next;
    logic signed [SAMPLE_BITS-1:0] cur_reg;
    logic signed [SAMPLE_BITS-1:0] cur_next;
    logic signed [DIFF_W-1:0]      diff_reg;
    logic signed [DIFF_W-1:0]      diff_next;
    logic                          fin_reg;
    logic                          fin_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    out_item_t                     out_data_reg;
    out_item_t                     out_data_next;

    logic                          slot_free;
    logic [SUM_W-1:0]              pos_ext;
    logic [SUM_W-1:0]              pos_sum;
    logic                          in_interval;
    logic                          last_copy;
    logic                          end_of_run;
    logic                          tail_follows;
    logic signed [PROD_W-1:0]      product;
    logic signed [PROD_W-1:0]      scaled;
    logic signed [SAMPLE_BITS-1:0] lerp_value;

    assign slot_free    = !out_valid_reg || !out_stall;
    assign pos_ext      = {1'b0, pos_reg};
    assign pos_sum      = pos_ext + {1'b0, step};
    assign in_interval  = (pos_ext < ONE_SUM);
    assign last_copy    = ({1'b0, chan_reg} == (chans - CHANS_W'(1)));
    assign end_of_run   = (pos_sum >= ONE_SUM);
    // On a final frame the interpolation run is followed by a run of held samples.
    assign tail_follows = fin_reg && (pos_sum < TWO_SUM);

    // Flooring shift of difference times fraction, then offset by the older sample.
    assign product    = diff_reg * $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
    assign scaled     = product >>> FRAC_BITS;
    assign lerp_value = prev_reg + scaled[SAMPLE_BITS-1:0];

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign status.idle   = (state_reg == S_IDLE);
    assign status.pos    = pos_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        chan_next      = chan_reg;
        value_next     = value_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        diff_next      = diff_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        pop            = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop        = 1'b1;
                    prev_next  = head.prev;
                    cur_next   = head.cur;
                    fin_next   = head.fin;
                    diff_next  = {head.cur[SAMPLE_BITS-1], head.cur}
                               - {head.prev[SAMPLE_BITS-1], head.prev};
                    state_next = head.has_prev ? S_A_CALC : S_B_CALC;
                end
            end
            S_A_CALC:
            begin
                if (in_interval)
                begin
                    value_next = lerp_value;
                    chan_next  = '0;
                    state_next = S_A_EMIT;
                end
                else
                begin
                    // Position now counts from the current sample.
                    pos_next   = POS_W'(pos_ext - ONE_SUM);
                    state_next = S_B_CALC;
                end
            end
            S_A_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.sample_out  = value_reg;
                    out_data_next.channel     = chan_reg;
                    out_data_next.run_last    = last_copy && end_of_run && !tail_follows;
                    out_data_next.stream_done = last_copy && end_of_run && !tail_follows
                                              && fin_reg;
                    if (last_copy)
                    begin
                        pos_next   = POS_W'(pos_sum);
                        state_next = S_A_CALC;
                    end
                    else
                    begin
                        chan_next = chan_reg + 1'b1;
                    end
                end
            end
            S_B_CALC:
            begin
                if (fin_reg && in_interval)
                begin
                    value_next = cur_reg;
                    chan_next  = '0;
                    state_next = S_B_EMIT;
                end
                else
                begin
                    if (fin_reg)
                    begin
                        pos_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_B_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.sample_out  = value_reg;
                    out_data_next.channel     = chan_reg;
                    out_data_next.run_last    = last_copy && end_of_run;
                    out_data_next.stream_done = last_copy && end_of_run;
                    if (last_copy)
                    begin
                        pos_next   = POS_W'(pos_sum);
                        state_next = S_B_CALC;
                    end
                    else
                    begin
                        chan_next = chan_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        diff_reg     <= diff_next;
        fin_reg      <= fin_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            chan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/linear_interp_resampler.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation sample rate converter: one source sample in, a run
// of interpolated samples out, each repeated across the output channels.
// ----------------------------------------------------------------------------
//  Port group   Handshake            Word
//  in           in_valid / in_stall  in_data  (sample_in, final_frame)
//  out          out_valid/out_stall  out_data (sample_out, channel, run_last,
//                                              stream_done)
//  cfg          cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// The back end sends the copies of an output position one word per cycle
// while out_stall is low; the interpolation product is registered before its
// copies go out, and each input word adds dequeue and end-of-interval handling.
// The queue takes up to QUEUE_DEPTH input words ahead of the back end.
// Reset is asynchronous and active low; after it the stream starts anew.
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_defines.svh"

module linear_interp_resampler #(
    parameter int QUEUE_DEPTH = lirs_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  lirs_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output lirs_pkg::out_item_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lirs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lirs_pkg::STEP_W-1:0]      cfg_data
);
    import lirs_pkg::*;

    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic [CHANS_W-1:0] chans_reg;
    logic [CHANS_W-1:0] chans_next;
    logic [STEP_W-1:0]  step_eff;
    logic [CHANS_W-1:0] chans_eff;

    logic               q_full;
    logic               push;
    cmd_t               push_cmd;
    cmd_t               head;
    logic               head_valid;
    logic               pop;
    back_status_t       back_status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        step_next  = step_reg;
        chans_next = chans_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STEP_RATIO:      step_next  = cfg_data;
                REG_OUTPUT_CHANNELS: chans_next = cfg_data[CHANS_W-1:0];
                default:             step_next  = step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ONE_POS;
            chans_reg <= CHANS_W'(2);
        end
        else
        begin
            step_reg  <= step_next;
            chans_reg <= chans_next;
        end
    end

    // Out-of-range settings are saturated before use.
    always_comb
    begin
        priority if (step_reg < STEP_MIN)
            step_eff = STEP_MIN;
        else if (step_reg > STEP_MAX)
            step_eff = STEP_MAX;
        else
            step_eff = step_reg;

        priority if (chans_reg == '0)
            chans_eff = CHANS_W'(1);
        else if (chans_reg > CHANS_MAX)
            chans_eff = CHANS_MAX;
        else
            chans_eff = chans_reg;
    end

    lirs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    lirs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    lirs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .step       (step_eff),
        .chans      (chans_eff),
        .out_data   (out_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (back_status)
    );

    `LIRS_ASSERT_IMPLY(a_done_is_run_last, out_valid && out_data.stream_done, out_data.run_last)
    `LIRS_ASSERT_IMPLY(a_channel_in_range, out_valid, (({1'b0, out_data.channel}) < chans_eff))
    `LIRS_ASSERT_ALWAYS(a_position_bounded, (back_status.pos < POS_BOUND))
    `LIRS_ASSERT_IMPLY(a_idle_pops_head, back_status.idle && head_valid, pop)

endmodule
